>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the hasher.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

>>> sv/sha_pkg.sv
// ---------------------------------------------------------------------------
// SHA-256 package
// Types, constants and round functions of the stream hasher.
// ---------------------------------------------------------------------------
package sha_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic CMD_DATA   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } item_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMP,
        S_ADD,
        S_EMIT
    } core_state_t;

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] IV_TABLE [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] a);
        big_s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] e);
        big_s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
    endfunction

    function automatic logic [31:0] small_s0(input logic [31:0] x);
        small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_s1(input logic [31:0] x);
        small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

>>> sv/sha_if.sv
// ---------------------------------------------------------------------------
// Hasher channel interfaces
// Valid/ready channels for message beats and digest beats.
// ---------------------------------------------------------------------------
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] data_byte;

    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;

    modport source (output valid, output digest_word, output word_index, output last,
                    input ready);
    modport sink (input valid, input digest_word, input word_index, input last,
                  output ready);
endinterface

>>> sv/sha_queue.sv
// ---------------------------------------------------------------------------
// Hasher input queue
// Accepts message beats and holds them until the core takes them.
// ---------------------------------------------------------------------------
module sha_queue #(
    parameter int Depth = sha_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sha_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           avail,
    output sha_pkg::item_t head
);
    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    sha_pkg::item_t   mem_reg [Depth];
    logic [PtrW-1:0]  wr_ptr_reg;
    logic [PtrW-1:0]  rd_ptr_reg;
    logic [CntW-1:0]  count_reg;

    assign full  = (count_reg == CntW'(Depth));
    assign avail = (count_reg != '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop && avail)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CntW'(push && !full) - CntW'(pop && avail);
        end
    end
endmodule

>>> sv/sha_core.sv
// ---------------------------------------------------------------------------
// Hasher core
// Packs bytes into the block, runs the rounds, pads and emits the digest.
// ---------------------------------------------------------------------------
module sha_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           avail,
    input  sha_pkg::item_t head,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [31:0]    out_word,
    output logic [2:0]     out_index,
    output logic           out_last
);
    sha_pkg::core_state_t state_reg;
    sha_pkg::core_state_t state_next;

    logic [31:0] w_reg    [16];
    logic [31:0] st_reg   [8];
    logic [31:0] hash_reg [8];
    logic [5:0]  fill_reg;
    logic [5:0]  rnd_reg;
    logic [63:0] bits_reg;
    logic [63:0] len_reg;
    logic        fin_reg;
    logic        extra_reg;
    logic [2:0]  idx_reg;
    logic        out_valid_reg;
    logic [31:0] out_word_reg;
    logic [2:0]  out_index_reg;
    logic        out_last_reg;

    logic        out_load;
    logic        need_extra;
    logic [63:0] total_len;
    logic [31:0] pad_w   [16];
    logic [31:0] len_w   [16];
    logic [31:0] sum_h   [8];
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] w_new;

    assign need_extra = (fill_reg >= sha_pkg::LEN_POS);
    assign total_len  = bits_reg + {55'd0, fill_reg, 3'b000};

    always_comb
    begin
        logic [7:0] b;
        for (int p = 0; p < 64; p++)
        begin
            if (6'(p) < fill_reg)
            begin
                b = w_reg[p / 4][31 - 8 * (p % 4) -: 8];
            end
            else if (6'(p) == fill_reg)
            begin
                b = sha_pkg::PAD_BYTE;
            end
            else if (!need_extra && p >= 56)
            begin
                b = total_len[8 * (63 - p) +: 8];
            end
            else
            begin
                b = 8'h00;
            end
            pad_w[p / 4][31 - 8 * (p % 4) -: 8] = b;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 14; i++)
        begin
            len_w[i] = '0;
        end
        len_w[14] = len_reg[63:32];
        len_w[15] = len_reg[31:0];
        for (int i = 0; i < 8; i++)
        begin
            sum_h[i] = hash_reg[i] + st_reg[i];
        end
    end

    assign t1 = st_reg[7] + sha_pkg::big_s1(st_reg[4])
              + ((st_reg[4] & st_reg[5]) ^ (~st_reg[4] & st_reg[6]))
              + sha_pkg::K_TABLE[rnd_reg] + w_reg[0];
    assign t2 = sha_pkg::big_s0(st_reg[0])
              + ((st_reg[0] & st_reg[1]) ^ (st_reg[0] & st_reg[2]) ^ (st_reg[1] & st_reg[2]));
    assign w_new = w_reg[0] + sha_pkg::small_s0(w_reg[1]) + w_reg[9]
                 + sha_pkg::small_s1(w_reg[14]);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sha_pkg::S_IDLE:
            begin
                if (avail && (head.cmd == sha_pkg::CMD_FINISH || fill_reg == 6'd63))
                begin
                    state_next = sha_pkg::S_COMP;
                end
            end
            sha_pkg::S_COMP:
            begin
                if (rnd_reg == 6'd63)
                begin
                    state_next = sha_pkg::S_ADD;
                end
            end
            sha_pkg::S_ADD:
            begin
                if (!fin_reg)
                begin
                    state_next = sha_pkg::S_IDLE;
                end
                else if (extra_reg)
                begin
                    state_next = sha_pkg::S_COMP;
                end
                else
                begin
                    state_next = sha_pkg::S_EMIT;
                end
            end
            sha_pkg::S_EMIT:
            begin
                if (out_load && idx_reg == 3'd7)
                begin
                    state_next = sha_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sha_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop      = (state_reg == sha_pkg::S_IDLE) && avail;
        out_load = (state_reg == sha_pkg::S_EMIT) && (!out_valid_reg || out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sha_pkg::S_IDLE;
            fill_reg      <= '0;
            bits_reg      <= '0;
            fin_reg       <= 1'b0;
            extra_reg     <= 1'b0;
            idx_reg       <= '0;
            rnd_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= sha_pkg::IV_TABLE[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                sha_pkg::S_IDLE:
                begin
                    rnd_reg <= '0;
                    if (pop)
                    begin
                        if (head.cmd == sha_pkg::CMD_FINISH)
                        begin
                            fin_reg   <= 1'b1;
                            extra_reg <= need_extra;
                        end
                        else
                        begin
                            fill_reg <= fill_reg + 1'b1;
                        end
                    end
                end
                sha_pkg::S_COMP:
                begin
                    rnd_reg <= rnd_reg + 1'b1;
                end
                sha_pkg::S_ADD:
                begin
                    rnd_reg <= '0;
                    idx_reg <= '0;
                    extra_reg <= 1'b0;
                    for (int i = 0; i < 8; i++)
                    begin
                        hash_reg[i] <= sum_h[i];
                    end
                    if (!fin_reg)
                    begin
                        bits_reg <= bits_reg + 64'd512;
                    end
                end
                sha_pkg::S_EMIT:
                begin
                    if (out_load)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        if (idx_reg == 3'd7)
                        begin
                            fill_reg <= '0;
                            bits_reg <= '0;
                            fin_reg  <= 1'b0;
                            for (int i = 0; i < 8; i++)
                            begin
                                hash_reg[i] <= sha_pkg::IV_TABLE[i];
                            end
                        end
                    end
                end
                default:
                begin
                    rnd_reg <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            sha_pkg::S_IDLE:
            begin
                if (pop)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        st_reg[i] <= hash_reg[i];
                    end
                    if (head.cmd == sha_pkg::CMD_FINISH)
                    begin
                        len_reg <= total_len;
                        for (int i = 0; i < 16; i++)
                        begin
                            w_reg[i] <= pad_w[i];
                        end
                    end
                    else
                    begin
                        w_reg[fill_reg[5:2]][8 * (3 - fill_reg[1:0]) +: 8] <= head.data_byte;
                    end
                end
            end
            sha_pkg::S_COMP:
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= w_reg[i + 1];
                end
                w_reg[15] <= w_new;
                st_reg[7] <= st_reg[6];
                st_reg[6] <= st_reg[5];
                st_reg[5] <= st_reg[4];
                st_reg[4] <= st_reg[3] + t1;
                st_reg[3] <= st_reg[2];
                st_reg[2] <= st_reg[1];
                st_reg[1] <= st_reg[0];
                st_reg[0] <= t1 + t2;
            end
            sha_pkg::S_ADD:
            begin
                if (fin_reg && extra_reg)
                begin
                    for (int i = 0; i < 16; i++)
                    begin
                        w_reg[i] <= len_w[i];
                    end
                    for (int i = 0; i < 8; i++)
                    begin
                        st_reg[i] <= sum_h[i];
                    end
                end
            end
            sha_pkg::S_EMIT:
            begin
                if (out_load)
                begin
                    out_word_reg  <= hash_reg[idx_reg];
                    out_index_reg <= idx_reg;
                    out_last_reg  <= (idx_reg == 3'd7);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_index = out_index_reg;
    assign out_last  = out_last_reg;
endmodule

>>> sv/sha256_stream_hasher_top.sv
// ---------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream and emits the digest as eight 32-bit beats.
// ---------------------------------------------------------------------------
//  Channel  Dir  Beat
//  in_if    in   cmd, data_byte (append a byte or finish the message)
//  out_if   out  digest_word, word_index, last (eight beats per finish)
//
// A data beat is packed into the block while the core is idle; the 64th byte of a block
// also starts the round loop (one round per cycle) and the chaining add.
// A finish pads the block and runs the rounds (again for an extra length block), then eight output beats.
// Reset loads the initial hash values and clears the length and fill count.
// The input queue keeps taking beats while the core is busy or stalled, until the queue is full.
`include "assert_macros.svh"

module sha256_stream_hasher_top #(
    parameter int QueueDepth = sha_pkg::QUEUE_DEPTH
) (
    input logic       clk,
    input logic       rst_n,
    sha_in_if.sink    in_if,
    sha_out_if.source out_if
);
    logic           q_full;
    logic           q_avail;
    logic           q_pop;
    sha_pkg::item_t q_head;
    sha_pkg::item_t q_in;

    assign q_in.cmd       = in_if.cmd;
    assign q_in.data_byte = in_if.data_byte;
    assign in_if.ready    = !q_full;

    sha_queue #(
        .Depth(QueueDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (in_if.valid),
        .push_item(q_in),
        .full     (q_full),
        .pop      (q_pop),
        .avail    (q_avail),
        .head     (q_head)
    );

    sha_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .avail    (q_avail),
        .head     (q_head),
        .pop      (q_pop),
        .out_valid(out_if.valid),
        .out_ready(out_if.ready),
        .out_word (out_if.digest_word),
        .out_index(out_if.word_index),
        .out_last (out_if.last)
    );

    `ASSERT_IMPLIES(a_last_index, clk, rst_n, out_if.valid, out_if.last == (out_if.word_index == 3'd7))
    `ASSERT_NEXT(a_gap_after_last, clk, rst_n, out_if.valid && out_if.ready && out_if.last, !out_if.valid)
endmodule

>>> verif/tb_sha256_stream_hasher_top.sv
// ---------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Drives byte and finish beats into the hasher and checks each digest beat
// against a software SHA-256 predictor kept in step with the accepted beats.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

class sha_digest_board;
    logic [31:0] chain[8];
    logic [7:0]  block[64];
    int unsigned fill;
    logic [63:0] msg_bits;
    logic [31:0] want_word[$];
    logic [2:0]  want_index[$];
    logic        want_last[$];
    int unsigned errors;

    function new();
        errors = 0;
        start_message();
    endfunction

    function void start_message();
        chain = sha_pkg::IV_TABLE;
        fill = 0;
        msg_bits = '0;
    endfunction

    function logic [31:0] ror(logic [31:0] v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function void compress();
        logic [31:0] w[64];
        logic [31:0] s[8];
        logic [31:0] t1, t2, x, y;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = {block[4*i], block[4*i+1], block[4*i+2], block[4*i+3]};
        end
        for (int i = 16; i < 64; i++)
        begin
            x = w[i-15];
            y = w[i-2];
            w[i] = w[i-16] + (ror(x, 7) ^ ror(x, 18) ^ (x >> 3)) + w[i-7]
                 + (ror(y, 17) ^ ror(y, 19) ^ (y >> 10));
        end
        s = chain;
        for (int i = 0; i < 64; i++)
        begin
            t1 = s[7] + (ror(s[4], 6) ^ ror(s[4], 11) ^ ror(s[4], 25))
               + ((s[4] & s[5]) ^ (~s[4] & s[6])) + sha_pkg::K_TABLE[i] + w[i];
            t2 = (ror(s[0], 2) ^ ror(s[0], 13) ^ ror(s[0], 22))
               + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
            s[7] = s[6]; s[6] = s[5]; s[5] = s[4]; s[4] = s[3] + t1;
            s[3] = s[2]; s[2] = s[1]; s[1] = s[0]; s[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
        begin
            chain[i] += s[i];
        end
    endfunction

    function void note_beat(logic cmd, logic [7:0] data_byte);
        logic [63:0] total;
        if (cmd == sha_pkg::CMD_DATA)
        begin
            block[fill] = data_byte;
            fill++;
            if (fill == 64)
            begin
                compress();
                msg_bits += 64'd512;
                fill = 0;
            end
            return;
        end
        total = msg_bits + 64'(fill * 8);
        block[fill] = sha_pkg::PAD_BYTE;
        fill++;
        if (fill > 56)
        begin
            while (fill < 64) block[fill++] = 8'h00;
            compress();
            fill = 0;
        end
        while (fill < 56) block[fill++] = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            block[63-i] = total[8*i +: 8];
        end
        compress();
        for (int i = 0; i < 8; i++)
        begin
            want_word.push_back(chain[i]);
            want_index.push_back(3'(i));
            want_last.push_back(i == 7);
        end
        start_message();
    endfunction

    function void check_beat(logic [31:0] word, logic [2:0] index, logic last);
        logic [31:0] ew;
        logic [2:0]  ei;
        logic        el;
        if (want_word.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected digest beat: word %h index %0d last %0b",
                         word, index, last);
            return;
        end
        ew = want_word.pop_front();
        ei = want_index.pop_front();
        el = want_last.pop_front();
        if (word !== ew || index !== ei || last !== el)
        begin
            errors++;
            if (errors <= 10)
                $display("digest mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                         ew, ei, el, word, index, last);
        end
    endfunction

    function int pending();
        return want_word.size();
    endfunction
endclass

module tb_sha256_stream_hasher_top;
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   send_idle = 0;
    int   recv_idle = 0;
    longint cycles = 0;
    sha_digest_board board = new();

    sha_in_if  in_if ();
    sha_out_if out_if ();

    sha256_stream_hasher_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_if  (in_if),
        .out_if (out_if)
    );

    initial
    begin
        in_if.valid = 1'b0;
        in_if.cmd = sha_pkg::CMD_DATA;
        in_if.data_byte = 8'h00;
        out_if.ready = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 2000000)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        if (rst_n)
        begin
            if (in_if.valid && in_if.ready)
                board.note_beat(in_if.cmd, in_if.data_byte);
            if (out_if.valid && out_if.ready)
                board.check_beat(out_if.digest_word, out_if.word_index, out_if.last);
            out_if.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send_beat(logic cmd, logic [7:0] data_byte);
        while ($urandom_range(99) < send_idle)
        begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.cmd <= cmd;
        in_if.data_byte <= data_byte;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
    endtask

    task automatic send_message(int len);
        for (int i = 0; i < len; i++)
        begin
            send_beat(sha_pkg::CMD_DATA, 8'($urandom));
        end
        send_beat(sha_pkg::CMD_FINISH, 8'($urandom));
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0) @(posedge clk);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 6;
        recv_idle = 86;
        send_beat(sha_pkg::CMD_FINISH, 8'hff);
        send_beat(sha_pkg::CMD_DATA, 8'h00);
        send_beat(sha_pkg::CMD_DATA, 8'hff);
        send_beat(sha_pkg::CMD_DATA, 8'h55);
        send_beat(sha_pkg::CMD_FINISH, 8'haa);
        send_beat(sha_pkg::CMD_DATA, 8'haa);
        send_beat(sha_pkg::CMD_FINISH, 8'h00);
        drain();
        send_message(55);
        send_message(56);
        send_message(63);
        send_message(64);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 6 : (phase == 1) ? 86 : 0;
            recv_idle = (phase == 0) ? 86 : (phase == 1) ? 6 : 0;
            for (int m = 0; m < 3; m++)
            begin
                case ($urandom_range(3))
                    0: send_message($urandom_range(3));
                    1: send_message($urandom_range(50, 70));
                    default: send_message($urandom_range(40));
                endcase
            end
            if (phase == 1)
                drain();
        end
        drain();
        repeat (200) @(posedge clk);

        if (board.errors == 0 && board.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
